// ===== hdl/ftp_pkg.sv =====
// shared types, constants and helpers for the frame timing profiler
package ftp_pkg;

  typedef enum logic [2:0] {
    EV_BEGIN   = 3'd0,
    EV_END     = 3'd1,
    EV_PRESENT = 3'd2,
    EV_API     = 3'd3,
    EV_TEXTURE = 3'd4
  } ev_t;

  typedef struct packed {
    ev_t         ev;
    logic [1:0]  metric;
    logic [63:0] data;
  } item_t;

  localparam logic [1:0] RK_FRAME  = 2'd0;
  localparam logic [1:0] RK_WINDOW = 2'd1;
  localparam logic [1:0] RK_MARKER = 2'd2;

  localparam logic       CFG_RUN_SECONDS = 1'b0;
  localparam logic       CFG_SKIP_FRAMES = 1'b1;

  localparam logic [63:0] WINDOW_NS     = 64'd5000000000;
  localparam logic [29:0] SECOND_NS     = 30'd1000000000;
  localparam logic [15:0] WARMUP_RESET  = 16'd120;
  localparam int          REC_CAP_DEFAULT = 8192;
  localparam int          QUEUE_DEPTH   = 4;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

endpackage

// ===== hdl/ftp_front.sv =====
// front end: takes event transfers, drops unknown types, queues the rest
module ftp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         req_type,
  input  logic [63:0]        timestamp,
  input  logic [1:0]         api_metric,
  input  logic [63:0]        duration,
  output logic               q_valid,
  output ftp_pkg::item_t     q_item,
  input  logic               q_pop
);

  localparam int AW = $clog2(ftp_pkg::QUEUE_DEPTH);

  ftp_pkg::item_t  queue [ftp_pkg::QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     fill;
  logic            known;
  logic            push;
  logic            pop;
  ftp_pkg::item_t  new_item;

  assign in_stall = (fill == (AW+1)'(ftp_pkg::QUEUE_DEPTH));
  assign known    = (req_type <= 3'd4);
  assign push     = in_valid && !in_stall && known;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (fill != '0);
  assign q_item   = queue[rd_ptr];

  always_comb begin
    new_item.ev     = ftp_pkg::ev_t'(req_type);
    new_item.metric = api_metric;
    // durations and timestamps never matter for the same event
    new_item.data   = (req_type == ftp_pkg::EV_API || req_type == ftp_pkg::EV_TEXTURE) ?
                      duration : timestamp;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ===== hdl/ftp_back.sv =====
// back end: event state, frame metric sequencer, window sums and result register
module ftp_back #(
  parameter int RECORD_CAPACITY = ftp_pkg::REC_CAP_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               q_valid,
  input  ftp_pkg::item_t     q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         result_kind,
  output logic [3:0]         metric_index,
  output logic [63:0]        value,
  output logic [63:0]        maximum,
  output logic [15:0]        count,
  output logic [3:0]         window_index,
  output logic               last
);

  localparam logic [13:0] CAP = 14'(RECORD_CAPACITY);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CALC1 = 7'b0000010,
    ST_CALC2 = 7'b0000100,
    ST_CALC3 = 7'b0001000,
    ST_FRAME = 7'b0010000,
    ST_SUM   = 7'b0100000,
    ST_MARK  = 7'b1000000
  } state_t;

  state_t       state;
  logic [5:0]   run_seconds;
  logic [15:0]  skip_limit;
  logic [35:0]  run_lim;
  logic         enabled;

  logic         active_flag;
  logic         finished_flag;
  logic [15:0]  warmup_count;
  logic [63:0]  frame_start_time;
  logic [63:0]  last_end_time;
  logic [63:0]  texture_accum;
  logic [63:0]  last_present_time;
  logic [63:0]  present_gap;
  logic [15:0]  present_count;
  logic [63:0]  api_accum [4];
  logic [63:0]  window_sum [8];
  logic [63:0]  window_max [8];
  logic [15:0]  window_frames;
  logic [63:0]  elapsed_total;
  logic [13:0]  records_done;
  logic [3:0]   windows_done;

  logic [63:0]  now;
  logic [63:0]  m [10];
  logic [63:0]  outside;
  logic [63:0]  video;
  logic [63:0]  part01;
  logic [63:0]  part23;
  logic [63:0]  measured;
  logic [3:0]   idx;
  logic         fin;

  logic         can_load;
  logic         load;
  logic         close_now;
  logic         fin_now;
  logic [13:0]  rec_inc;
  logic [63:0]  cur_m;

  assign enabled  = (run_seconds >= 6'd1) && (run_seconds <= 6'd60);
  assign can_load = !out_valid || !out_stall;
  assign load     = can_load && (state inside {ST_FRAME, ST_SUM, ST_MARK});
  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign cur_m    = m[idx];
  assign rec_inc  = (records_done == 14'h3FFF) ? records_done : records_done + 14'd1;
  assign close_now = (window_sum[0] >= ftp_pkg::WINDOW_NS);
  assign fin_now  = (elapsed_total >= {28'd0, run_lim}) || (rec_inc == CAP);

  always_ff @(posedge clk) begin
    run_lim <= 36'(run_seconds) * 36'(ftp_pkg::SECOND_NS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_seconds <= '0;
      skip_limit  <= ftp_pkg::WARMUP_RESET;
    end else if (cfg_we) begin
      if (cfg_index == ftp_pkg::CFG_RUN_SECONDS) run_seconds <= cfg_data[5:0];
      else skip_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      active_flag       <= 1'b0;
      finished_flag     <= 1'b0;
      warmup_count      <= '0;
      frame_start_time  <= '0;
      last_end_time     <= '0;
      texture_accum     <= '0;
      last_present_time <= '0;
      present_gap       <= '0;
      present_count     <= '0;
      window_frames     <= '0;
      elapsed_total     <= '0;
      records_done      <= '0;
      windows_done      <= '0;
      idx               <= '0;
      fin               <= 1'b0;
      for (int i = 0; i < 4; i++) api_accum[i] <= '0;
      for (int i = 0; i < 8; i++) begin
        window_sum[i] <= '0;
        window_max[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            case (q_item.ev)
              ftp_pkg::EV_BEGIN: begin
                if (enabled && !finished_flag) begin
                  if (active_flag) begin
                    last_end_time     <= '0;
                    last_present_time <= '0;
                  end
                  active_flag      <= 1'b1;
                  frame_start_time <= q_item.data;
                  present_count    <= '0;
                  present_gap      <= '0;
                  for (int i = 0; i < 4; i++) api_accum[i] <= '0;
                end
              end
              ftp_pkg::EV_END: begin
                now   <= q_item.data;
                state <= ST_CALC1;
              end
              ftp_pkg::EV_PRESENT: begin
                if (active_flag) begin
                  if (present_count != 16'hFFFF) present_count <= present_count + 16'd1;
                  if (last_present_time != '0) present_gap <= q_item.data - last_present_time;
                  last_present_time <= q_item.data;
                end
              end
              ftp_pkg::EV_API: begin
                if (active_flag)
                  api_accum[q_item.metric] <= ftp_pkg::sat_add(api_accum[q_item.metric],
                                                               q_item.data);
              end
              ftp_pkg::EV_TEXTURE: begin
                if (enabled && !finished_flag)
                  texture_accum <= ftp_pkg::sat_add(texture_accum, q_item.data);
              end
              default: ;
            endcase
          end
        end
        ST_CALC1: begin
          if (!active_flag) begin
            state <= ST_IDLE;
          end else begin
            active_flag   <= 1'b0;
            last_end_time <= now;
            texture_accum <= '0;
            if (warmup_count < skip_limit || last_end_time == '0) begin
              if (warmup_count != 16'hFFFF) warmup_count <= warmup_count + 16'd1;
              state <= ST_IDLE;
            end else begin
              m[0]    <= now - last_end_time;
              outside <= frame_start_time - last_end_time;
              video   <= now - frame_start_time;
              m[2]    <= texture_accum;
              part01  <= ftp_pkg::sat_add(api_accum[0], api_accum[1]);
              part23  <= ftp_pkg::sat_add(api_accum[2], api_accum[3]);
              for (int i = 0; i < 4; i++) m[4+i] <= api_accum[i];
              m[8]    <= present_gap;
              m[9]    <= {48'd0, present_count};
              state   <= ST_CALC2;
            end
          end
        end
        ST_CALC2: begin
          measured <= ftp_pkg::sat_add(part01, part23);
          m[1]     <= (outside >= m[2]) ? outside - m[2] : '0;
          state    <= ST_CALC3;
        end
        ST_CALC3: begin
          m[3]          <= (video >= measured) ? video - measured : '0;
          elapsed_total <= ftp_pkg::sat_add(elapsed_total, m[0]);
          idx           <= '0;
          state         <= ST_FRAME;
        end
        ST_FRAME: begin
          if (can_load) begin
            result_kind  <= ftp_pkg::RK_FRAME;
            metric_index <= idx;
            value        <= cur_m;
            maximum      <= '0;
            count        <= {2'b00, records_done};
            window_index <= windows_done;
            last         <= (idx == 4'd9) && !close_now && !fin_now;
            if (idx < 4'd8) begin
              window_sum[idx[2:0]] <= ftp_pkg::sat_add(window_sum[idx[2:0]], cur_m);
              if (cur_m > window_max[idx[2:0]]) window_max[idx[2:0]] <= cur_m;
            end
            idx <= (idx == 4'd9) ? 4'd0 : idx + 4'd1;
            if (idx == 4'd9) begin
              // window sum of interval already folded in on the first transfer
              records_done  <= rec_inc;
              if (window_frames != 16'hFFFF) window_frames <= window_frames + 16'd1;
              fin           <= fin_now;
              state         <= (close_now || fin_now) ? ST_SUM : ST_IDLE;
            end
          end
        end
        ST_SUM: begin
          if (can_load) begin
            result_kind  <= ftp_pkg::RK_WINDOW;
            metric_index <= idx;
            value        <= window_sum[idx[2:0]];
            maximum      <= window_max[idx[2:0]];
            count        <= window_frames;
            window_index <= windows_done;
            last         <= (idx == 4'd7) && !fin;
            idx          <= idx + 4'd1;
            if (idx == 4'd7) begin
              if (windows_done != 4'd15) windows_done <= windows_done + 4'd1;
              window_frames <= '0;
              for (int i = 0; i < 8; i++) begin
                window_sum[i] <= '0;
                window_max[i] <= '0;
              end
              state <= fin ? ST_MARK : ST_IDLE;
            end
          end
        end
        ST_MARK: begin
          if (can_load) begin
            result_kind   <= ftp_pkg::RK_MARKER;
            metric_index  <= '0;
            value         <= elapsed_total;
            maximum       <= '0;
            count         <= {2'b00, records_done};
            window_index  <= windows_done;
            last          <= 1'b1;
            finished_flag <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_sum_has_frames: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM) |-> (window_frames != '0))
    else $error("window summary with no frames");

  a_mark_only_on_finish: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MARK) |-> fin)
    else $error("marker without finish");

  a_finished_idle: assert property (@(posedge clk) disable iff (rst)
    finished_flag |-> !active_flag)
    else $error("frame active after run finished");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == ST_IDLE))
    else $error("queue popped while sequencer busy");

endmodule

// ===== hdl/frame_timing_profiler.sv =====
// frame timing profiler: event queue, metric sequencer and result register
// an event transfer is taken whenever the four-entry queue has room; unknown types are dropped
// begin, present, api and texture events are handled in the idle state, an unrecorded end also visits CALC1
// a recorded frame end passes CALC1, CALC2, CALC3, then 10 frame results, 8 window and 1 marker as due
// results leave through one output register, held while out_stall; the first follows CALC1 to CALC3
// synchronous reset clears all run state; the frame skip limit resets to 120, run_seconds to 0
module frame_timing_profiler #(
  parameter int RECORD_CAPACITY = ftp_pkg::REC_CAP_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [2:0]   req_type,
  input  logic [63:0]  timestamp,
  input  logic [1:0]   api_metric,
  input  logic [63:0]  duration,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [1:0]   result_kind,
  output logic [3:0]   metric_index,
  output logic [63:0]  value,
  output logic [63:0]  maximum,
  output logic [15:0]  count,
  output logic [3:0]   window_index,
  output logic         last
);

  logic            q_valid;
  logic            q_pop;
  ftp_pkg::item_t  q_item;

  ftp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .timestamp  (timestamp),
    .api_metric (api_metric),
    .duration   (duration),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  ftp_back #(
    .RECORD_CAPACITY (RECORD_CAPACITY)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .metric_index (metric_index),
    .value        (value),
    .maximum      (maximum),
    .count        (count),
    .window_index (window_index),
    .last         (last)
  );

endmodule
